// ===== hw/rtl/drpb_pkg.sv =====
package drpb_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHIP_COUNT = 2'd0,
    REG_SNAP       = 2'd1,
    REG_MIN_CORR   = 2'd2,
    REG_BLEND_TIME = 2'd3
  } cfg_reg_t;

  localparam logic [6:0]  SHIP_COUNT_RST = 7'd0;
  localparam logic [30:0] SNAP_RST       = 31'd12800;
  localparam logic [15:0] MIN_CORR_RST   = 16'd26;
  localparam logic [15:0] BLEND_TIME_RST = 16'd2048;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic [6:0]  ship_count;
    logic [30:0] snap_limit;
    logic [15:0] min_correction;
    logic [15:0] blend_time;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [5:0]         vessel;
    logic [31:0]        now_time;
    logic signed [31:0] in_x;
    logic signed [31:0] in_z;
    logic signed [15:0] in_speed;
    logic [15:0]        in_bearing;
    logic signed [15:0] in_turn;
  } item_t;

  typedef struct packed {
    logic               in_range;
    logic signed [31:0] out_x;
    logic signed [31:0] out_z;
    logic signed [15:0] out_speed;
    logic [15:0]        out_bearing;
    logic signed [15:0] out_turn;
  } result_t;

  typedef struct packed {
    logic  in_range;
    item_t item;
  } qent_t;

  typedef struct packed {
    logic [31:0]        last_time;
    logic signed [31:0] last_x;
    logic signed [31:0] last_z;
    logic signed [15:0] last_speed;
    logic [15:0]        last_bearing;
    logic signed [15:0] last_turn;
    logic               blend_on;
    logic [31:0]        blend_start;
    logic signed [31:0] error_x;
    logic signed [31:0] error_z;
    logic signed [15:0] error_bearing;
  } ent_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RD, S_DT, S_ROT, S_DIST, S_CORD, S_Q, S_MX, S_MZ,
    S_SQX, S_SQZ, S_SUM, S_CMP, S_EL, S_DIV, S_FF, S_S, S_EX, S_EZ, S_EB, S_OUT
  } back_state_t;

  function automatic logic [31:0] atan_unit(input logic [3:0] i);
    logic [31:0] r;
    case (i)
      4'd0:    r = 32'd536870912;
      4'd1:    r = 32'd316933406;
      4'd2:    r = 32'd167458907;
      4'd3:    r = 32'd85004756;
      4'd4:    r = 32'd42667331;
      4'd5:    r = 32'd21354465;
      4'd6:    r = 32'd10679838;
      4'd7:    r = 32'd5340245;
      4'd8:    r = 32'd2670163;
      4'd9:    r = 32'd1335087;
      4'd10:   r = 32'd667544;
      4'd11:   r = 32'd333772;
      4'd12:   r = 32'd166886;
      4'd13:   r = 32'd83443;
      4'd14:   r = 32'd41722;
      default: r = 32'd20861;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [16:0] to_q15(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [16:0] r;
    t = (35'(v) + 35'sd16384) >>> 15;
    if (t > 35'sd32768) r = 17'sd32768;
    else if (t < -35'sd32768) r = -17'sd32768;
    else r = t[16:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/drpb_if.sv =====
interface drpb_item_if;
  logic            valid;
  logic            ready;
  drpb_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface drpb_result_if;
  logic              valid;
  logic              ready;
  drpb_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dead_reckoning_position_blender_unit.sv =====
// Channel   Role    Word
// item      sink    drpb_pkg::item_t   (report or query for one vessel)
// result    source  drpb_pkg::result_t (one word for every item)
// cfg_*     write   index + data, taken on any cycle with cfg_we high
//
// Order: one item at a time through the back end. An out-of-range word goes
// straight to the result; a first report skips the 16-step CORDIC, a later
// report and every in-range query run it, and a query within a blend also
// runs the 16-step fraction divider.
// Reset: synchronous; afterwards a clearing pass writes all MAX_VESSELS entries
// of the vessel table to zero, and items wait in the queue until it finishes.
// Stalls: a two-word queue parts the front from the back, and an output
// register lets the back finish its next word while a result waits.
module dead_reckoning_position_blender_unit #(
  parameter int MAX_VESSELS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  drpb_item_if.sink                       item,
  drpb_result_if.source                   result,
  input  logic                            cfg_we,
  input  logic [drpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drpb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import drpb_pkg::*;

  cfg_t  cfg;
  logic  q_valid, q_ready;
  qent_t q_data;

  // configuration registers; the user must write them only while the unit is idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ship_count     <= SHIP_COUNT_RST;
      cfg.snap_limit     <= SNAP_RST;
      cfg.min_correction <= MIN_CORR_RST;
      cfg.blend_time     <= BLEND_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SHIP_COUNT: cfg.ship_count     <= cfg_data[6:0];
        REG_SNAP:       cfg.snap_limit     <= cfg_data[30:0];
        REG_MIN_CORR:   cfg.min_correction <= cfg_data[15:0];
        REG_BLEND_TIME: cfg.blend_time     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // front: accept and classify, hold up to two words
  drpb_front #(.MAX_VESSELS(MAX_VESSELS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .ship_count (cfg.ship_count),
    .item       (item),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_data     (q_data)
  );

  // back: table access, dead reckoning, blend and result register
  drpb_back #(.MAX_VESSELS(MAX_VESSELS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .result  (result)
  );

endmodule

// ===== hw/rtl/drpb_front.sv =====
module drpb_front #(
  parameter int MAX_VESSELS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [6:0]      ship_count,
  drpb_item_if.sink       item,
  output logic            q_valid,
  input  logic            q_ready,
  output drpb_pkg::qent_t q_data
);
  import drpb_pkg::*;

  qent_t      slot [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop, in_range;

  // classify: index must fall inside both the programmed count and the table
  assign in_range = ({1'b0, item.data.vessel} < ship_count) &&
                    (int'(item.data.vessel) < MAX_VESSELS);

  assign item.ready = (cnt != 2'd2);
  assign q_valid    = (cnt != 2'd0);
  assign q_data     = slot[rp];
  assign push       = item.valid && item.ready;
  assign pop        = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp].in_range <= in_range;
      slot[wp].item     <= item.data;
    end
  end

endmodule

// ===== hw/rtl/drpb_back.sv =====
module drpb_back #(
  parameter int MAX_VESSELS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  drpb_pkg::cfg_t  cfg,
  input  logic            q_valid,
  output logic            q_ready,
  input  drpb_pkg::qent_t q_data,
  drpb_result_if.source   result
);
  import drpb_pkg::*;

  localparam int AW = (MAX_VESSELS > 1) ? $clog2(MAX_VESSELS) : 1;

  back_state_t st, st_next;

  ent_t    mem [MAX_VESSELS];
  ent_t    rd, wdata;
  logic    we;
  logic [AW-1:0] waddr, clr_cnt, cur_addr;
  logic [15:0]   vext;

  item_t   cur;
  result_t res_hold, out_data;
  logic    out_valid, load;

  logic [31:0]        dt;
  logic signed [48:0] rot, travel;
  logic signed [33:0] cx, cy, cz;
  logic               flip;
  logic [3:0]         it;
  logic signed [16:0] sq, cq;
  logic signed [31:0] px, pz;
  logic [15:0]        bear;
  logic [63:0]        ax, az, d2;
  logic [31:0]        min2;
  logic [61:0]        snap2;
  logic [15:0]        rem, f;
  logic [31:0]        ff;
  logic [16:0]        w;

  // combinational helpers
  logic [15:0]        avg, pb_dr;
  logic [31:0]        ang;
  logic signed [33:0] xs, ys, atn;
  logic signed [65:0] pmx, pmz, sqx, sqz;
  logic signed [32:0] dx, dz;
  logic [64:0]        dsum;
  logic               start_blend, ends;
  logic [31:0]        el;
  logic [16:0]        dtry;
  logic [49:0]        sp;
  logic signed [49:0] pex, pez;
  logic signed [33:0] peb;

  assign vext     = 16'(cur.vessel);
  assign cur_addr = vext[AW-1:0];

  assign avg   = rd.last_bearing + rot[26:11];
  assign pb_dr = rd.last_bearing + rot[25:10];
  assign ang   = {avg, 16'd0} ^ {(avg[15] ^ avg[14]), 31'd0};
  assign xs    = cx >>> it;
  assign ys    = cy >>> it;
  assign atn   = $signed({2'b00, atan_unit(it)});
  assign pmx   = travel * sq;
  assign pmz   = travel * cq;
  assign dx    = 33'(px) - 33'(cur.in_x);
  assign dz    = 33'(pz) - 33'(cur.in_z);
  assign sqx   = dx * dx;
  assign sqz   = dz * dz;
  assign dsum  = {1'b0, ax} + {1'b0, az};
  assign start_blend = (d2 > {32'd0, min2}) && (d2 < {2'd0, snap2});
  assign el    = (cur.now_time >= rd.blend_start) ? cur.now_time - rd.blend_start : 32'd0;
  assign ends  = el >= {16'd0, cfg.blend_time};
  assign dtry  = {rem, 1'b0};
  assign sp    = ff * (18'd196608 - {1'b0, f, 1'b0});
  assign pex   = rd.error_x * $signed({1'b0, w});
  assign pez   = rd.error_z * $signed({1'b0, w});
  assign peb   = rd.error_bearing * $signed({1'b0, w});

  // table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (st == S_RD) rd <= mem[cur_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_CLR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (st == S_CLR) clr_cnt <= clr_cnt + 1'b1;
      if (load) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= res_hold;
  end

  always_comb begin
    st_next = st;
    q_ready = 1'b0;
    we      = 1'b0;
    waddr   = cur_addr;
    wdata   = rd;
    load    = 1'b0;
    case (st)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = '0;
        if (clr_cnt == AW'(MAX_VESSELS - 1)) st_next = S_IDLE;
      end
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) st_next = q_data.in_range ? S_RD : S_OUT;
      end
      S_RD: st_next = S_DT;
      S_DT: begin
        if (cur.kind == KIND_REPORT && rd.last_time == 32'd0) st_next = S_CMP;
        else st_next = S_ROT;
      end
      S_ROT:  st_next = S_DIST;
      S_DIST: st_next = S_CORD;
      S_CORD: if (it == 4'd15) st_next = S_Q;
      S_Q:    st_next = S_MX;
      S_MX:   st_next = S_MZ;
      S_MZ:   st_next = (cur.kind == KIND_QUERY) ? S_EL : S_SQX;
      S_SQX:  st_next = S_SQZ;
      S_SQZ:  st_next = S_SUM;
      S_SUM:  st_next = S_CMP;
      S_CMP: begin
        we                 = 1'b1;
        wdata.last_time    = cur.now_time;
        wdata.last_x       = cur.in_x;
        wdata.last_z       = cur.in_z;
        wdata.last_speed   = cur.in_speed;
        wdata.last_bearing = cur.in_bearing;
        wdata.last_turn    = cur.in_turn;
        if (rd.last_time != 32'd0) begin
          if (start_blend) begin
            wdata.blend_on      = 1'b1;
            wdata.blend_start   = cur.now_time;
            wdata.error_x       = sat32(68'(dx));
            wdata.error_z       = sat32(68'(dz));
            wdata.error_bearing = $signed(bear - cur.in_bearing);
          end else begin
            wdata.blend_on = 1'b0;
          end
        end
        st_next = S_OUT;
      end
      S_EL: begin
        if (rd.blend_on && ends) begin
          we             = 1'b1;
          wdata.blend_on = 1'b0;
        end
        st_next = (rd.blend_on && !ends) ? S_DIV : S_OUT;
      end
      S_DIV: if (it == 4'd15) st_next = S_FF;
      S_FF:  st_next = S_S;
      S_S:   st_next = S_EX;
      S_EX:  st_next = S_EZ;
      S_EZ:  st_next = S_EB;
      S_EB:  st_next = S_OUT;
      S_OUT: begin
        if (!out_valid || result.ready) begin
          load    = 1'b1;
          st_next = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st)
      S_IDLE: begin
        if (q_valid) begin
          cur      <= q_data.item;
          res_hold <= '0;
        end
      end
      S_DT: dt <= (cur.now_time > rd.last_time) ? cur.now_time - rd.last_time : 32'd0;
      S_ROT: rot <= rd.last_turn * $signed({1'b0, dt});
      S_DIST: begin
        travel <= rd.last_speed * $signed({1'b0, dt});
        bear   <= pb_dr;
        flip   <= avg[15] ^ avg[14];
        cx     <= CORDIC_GAIN;
        cy     <= '0;
        cz     <= 34'($signed(ang));
        it     <= 4'd0;
      end
      S_CORD: begin
        if (!cz[33]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - atn;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + atn;
        end
        it <= it + 4'd1;
      end
      S_Q: begin
        sq <= flip ? -to_q15(cy) : to_q15(cy);
        cq <= flip ? -to_q15(cx) : to_q15(cx);
      end
      S_MX: px <= sat32(68'(rd.last_x) + 68'(pmx >>> 25));
      S_MZ: pz <= sat32(68'(rd.last_z) + 68'(pmz >>> 25));
      S_SQX: begin
        ax   <= sqx[63:0];
        min2 <= cfg.min_correction * cfg.min_correction;
      end
      S_SQZ: begin
        az    <= sqz[63:0];
        snap2 <= cfg.snap_limit * cfg.snap_limit;
      end
      S_SUM: d2 <= dsum[64] ? '1 : dsum[63:0];
      S_CMP: res_hold.in_range <= 1'b1;
      S_EL: begin
        rem <= el[15:0];
        f   <= '0;
        it  <= 4'd0;
        res_hold <= '{in_range: 1'b1, out_x: px, out_z: pz, out_speed: rd.last_speed,
                      out_bearing: bear, out_turn: rd.last_turn};
      end
      S_DIV: begin
        if (dtry >= {1'b0, cfg.blend_time}) begin
          rem <= 16'(dtry - {1'b0, cfg.blend_time});
          f   <= {f[14:0], 1'b1};
        end else begin
          rem <= dtry[15:0];
          f   <= {f[14:0], 1'b0};
        end
        it <= it + 4'd1;
      end
      S_FF: ff <= f * f;
      S_S:  w <= 17'd65536 - sp[48:32];
      S_EX: px <= sat32(68'(px) + 68'(pex >>> 16));
      S_EZ: pz <= sat32(68'(pz) + 68'(pez >>> 16));
      S_EB: begin
        res_hold <= '{in_range: 1'b1, out_x: px, out_z: pz, out_speed: rd.last_speed,
                      out_bearing: bear + peb[31:16], out_turn: rd.last_turn};
      end
      default: ;
    endcase
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule

// ===== tb/dead_reckoning_position_blender_unit_tb.sv =====
`timescale 1ns / 100ps

module dead_reckoning_position_blender_unit_tb;
  import drpb_pkg::*;

  localparam int  N_VESSEL    = 64;
  localparam int  STALL_LIMIT = 5000;
  localparam int  HOLD_CYCLES = 400;
  localparam int  SETTLE      = 80;

  // Arc-tangent steps of the rotation, 2^-32 turn per unit
  localparam longint ATAN_STEP [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861
  };
  localparam longint ROT_GAIN = 652032874;

  typedef struct {
    logic [31:0]        t;
    logic signed [31:0] x;
    logic signed [31:0] z;
    logic signed [15:0] speed;
    logic [15:0]        bearing;
    logic signed [15:0] turn;
    bit                 blending;
    logic [31:0]        blend_t0;
    logic signed [31:0] err_x;
    logic signed [31:0] err_z;
    logic signed [15:0] err_b;
  } track_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  drpb_item_if   item_ch ();
  drpb_result_if res_ch ();

  dead_reckoning_position_blender_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model copy of the vessel table and the registers
  track_t      tracks [N_VESSEL];
  logic [6:0]  m_ship_count;
  logic [30:0] m_snap;
  logic [15:0] m_min_corr;
  logic [15:0] m_blend_time;

  result_t     pending_fixes [$];
  int          mismatches;
  int          checked;
  int          words_sent;
  int          reports_sent;
  int          queries_sent;
  int          idle_cycles;
  bit          tx_calm;
  bit          rx_calm;
  bit          hold_off;
  logic [31:0] clock_of [N_VESSEL];

  // Clock: 12 ns period
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Model arithmetic
  // ---------------------------------------------------------------------------
  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_q15(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32768) r = 32768;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  // Sine and cosine of a binary angle by a sixteen-step rotation
  function automatic void heading_sincos(input logic [15:0] ang, output longint s,
                                         output longint c);
    logic [31:0] a;
    bit          flip;
    longint      x, y, z, xs, ys;
    a    = {ang, 16'h0000};
    flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
    if (flip) a = a - 32'h8000_0000;
    z = longint'(signed'(a));
    x = ROT_GAIN;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ATAN_STEP[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ATAN_STEP[i];
      end
    end
    s = round_q15(y);
    c = round_q15(x);
    if (flip) begin
      s = -s;
      c = -c;
    end
  endfunction

  // Advance a vessel along its arc to time now
  function automatic void dead_reckon(input int v, input logic [31:0] now,
                                      output longint px, output longint pz,
                                      output logic [15:0] pb);
    logic [31:0] dt;
    longint      rot, travel, s, c;
    logic [15:0] mid;
    dt     = (now > tracks[v].t) ? now - tracks[v].t : 32'd0;
    rot    = longint'(tracks[v].turn) * longint'({32'd0, dt});
    mid    = tracks[v].bearing + rot[26:11];
    pb     = tracks[v].bearing + rot[25:10];
    travel = longint'(tracks[v].speed) * longint'({32'd0, dt});
    heading_sincos(mid, s, c);
    px = clamp32(longint'(tracks[v].x) + ((travel * s) >>> 25));
    pz = clamp32(longint'(tracks[v].z) + ((travel * c) >>> 25));
  endfunction

  function automatic longint unsigned square_mag(input longint d);
    longint unsigned a;
    a = (d < 0) ? longint'(-d) : d;
    return a * a;
  endfunction

  // Work out the word the block should return, and update the table
  function automatic result_t blend_fix(input item_t w);
    result_t         r;
    int              v;
    longint          px, pz, dx, dz, wgt, pbl;
    logic [15:0]     pb;
    longint unsigned sa, sb, d2, f, sm;
    logic [31:0]     el;
    r = '0;
    v = int'(w.vessel);
    if (v >= int'(m_ship_count)) return r;
    r.in_range = 1'b1;
    if (w.kind == KIND_REPORT) begin
      if (tracks[v].t != 32'd0) begin
        dead_reckon(v, w.now_time, px, pz, pb);
        dx = px - longint'(w.in_x);
        dz = pz - longint'(w.in_z);
        sa = square_mag(dx);
        sb = square_mag(dz);
        d2 = sa + sb;
        if (d2 < sa) d2 = '1;
        if (d2 > longint'(m_min_corr) * longint'(m_min_corr) &&
            d2 < longint'(m_snap) * longint'(m_snap)) begin
          tracks[v].blending = 1'b1;
          tracks[v].blend_t0 = w.now_time;
          tracks[v].err_x    = 32'(clamp32(dx));
          tracks[v].err_z    = 32'(clamp32(dz));
          tracks[v].err_b    = pb - w.in_bearing;
        end else begin
          tracks[v].blending = 1'b0;
        end
      end
      tracks[v].t       = w.now_time;
      tracks[v].x       = w.in_x;
      tracks[v].z       = w.in_z;
      tracks[v].speed   = w.in_speed;
      tracks[v].bearing = w.in_bearing;
      tracks[v].turn    = w.in_turn;
      return r;
    end
    dead_reckon(v, w.now_time, px, pz, pb);
    if (tracks[v].blending) begin
      el = (w.now_time >= tracks[v].blend_t0) ? w.now_time - tracks[v].blend_t0 : 32'd0;
      if (el >= {16'd0, m_blend_time}) begin
        tracks[v].blending = 1'b0;
      end else begin
        // Smoothstep weight on the remaining share of the error
        f   = ({32'd0, el} << 16) / m_blend_time;
        sm  = (f * f * (64'd196608 - 2 * f)) >> 32;
        wgt = 65536 - longint'(sm);
        px  = clamp32(px + ((longint'(tracks[v].err_x) * wgt) >>> 16));
        pz  = clamp32(pz + ((longint'(tracks[v].err_z) * wgt) >>> 16));
        pbl = longint'(pb) + ((longint'(tracks[v].err_b) * wgt) >>> 16);
        pb  = pbl[15:0];
      end
    end
    r.out_x       = px[31:0];
    r.out_z       = pz[31:0];
    r.out_speed   = tracks[v].speed;
    r.out_bearing = pb;
    r.out_turn    = tracks[v].turn;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Send one word: idle a random gap, offer it, hold until taken
  task automatic send_word(input item_t w);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= w;
    do @(negedge clk); while (!item_ch.ready);
    @(posedge clk);
    pending_fixes = {pending_fixes, blend_fix(w)};
    words_sent++;
    if (w.kind == KIND_REPORT) reports_sent++;
    else queries_sent++;
    if (w.vessel < N_VESSEL && w.now_time > clock_of[w.vessel]) clock_of[w.vessel] = w.now_time;
  endtask

  // Drop valid, then let the block empty
  task automatic drain;
    item_ch.valid <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all four registers on consecutive edges; no words are in flight here
  task automatic program_regs(input logic [6:0] sc, input logic [30:0] st,
                              input logic [15:0] mc, input logic [15:0] bt);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SHIP_COUNT;
    cfg_data  <= CFG_DATA_W'(sc);
    @(posedge clk);
    cfg_index <= REG_SNAP;
    cfg_data  <= st;
    @(posedge clk);
    cfg_index <= REG_MIN_CORR;
    cfg_data  <= CFG_DATA_W'(mc);
    @(posedge clk);
    cfg_index <= REG_BLEND_TIME;
    cfg_data  <= CFG_DATA_W'(bt);
    @(posedge clk);
    cfg_we <= 1'b0;
    m_ship_count = sc;
    m_snap       = st;
    m_min_corr   = mc;
    m_blend_time = bt;
  endtask

  function automatic item_t make_report(input int v, input logic [31:0] t,
                                        input longint x, input longint z,
                                        input int spd, input int brg, input int trn);
    item_t w;
    w            = '0;
    w.kind       = KIND_REPORT;
    w.vessel     = v[5:0];
    w.now_time   = t;
    w.in_x       = x[31:0];
    w.in_z       = z[31:0];
    w.in_speed   = spd[15:0];
    w.in_bearing = brg[15:0];
    w.in_turn    = trn[15:0];
    return w;
  endfunction

  function automatic item_t make_query(input int v, input logic [31:0] t);
    item_t w;
    w          = '0;
    w.kind     = KIND_QUERY;
    w.vessel   = v[5:0];
    w.now_time = t;
    return w;
  endfunction

  // A plausible word: later time, a query or a report near the dead-reckoned spot
  function automatic item_t plausible_word(input int nv);
    item_t       w;
    int          v, pick;
    logic [31:0] t;
    longint      px, pz, off;
    logic [15:0] pb;
    v    = $urandom_range(0, nv - 1);
    t    = clock_of[v] + $urandom_range(1, 3000);
    pick = $urandom_range(0, 9);
    if (pick < 5) return make_query(v, t);
    dead_reckon(v, t, px, pz, pb);
    case ($urandom_range(0, 3))
      0:       off = $urandom_range(0, 30);
      1:       off = $urandom_range(0, 3000);
      2:       off = $urandom_range(0, 60000);
      default: off = $urandom_range(0, 500000);
    endcase
    if ($urandom_range(0, 1)) off = -off;
    w = make_report(v, t, px + off, pz - off / 2, $urandom_range(0, 4000) - 1000,
                    int'(pb) + $urandom_range(0, 600) - 300,
                    $urandom_range(0, 4000) - 2000);
    return w;
  endfunction

  function automatic item_t noise_word;
    item_t w;
    w.kind       = 1'($urandom_range(0, 1));
    w.vessel     = 6'($urandom_range(0, 63));
    w.now_time   = $urandom;
    w.in_x       = $urandom;
    w.in_z       = $urandom;
    w.in_speed   = 16'($urandom);
    w.in_bearing = 16'($urandom);
    w.in_turn    = 16'($urandom);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Hand-picked words: unreported entry, time-zero report, blend start,
  // query before the blend, blend run-out, snap, tiny correction, extremes
  task automatic test_directed;
    longint      px, pz;
    logic [15:0] pb;
    program_regs(7'd64, 31'd12800, 16'd26, 16'd2048);
    send_word(make_query(0, 32'd500));
    send_word(make_report(0, 32'd0, 1000, 2000, 256, 16'h4000, 0));
    send_word(make_report(0, 32'd1000, 5000, -7000, 512, 16'h2000, 100));
    dead_reckon(0, 32'd3000, px, pz, pb);
    send_word(make_report(0, 32'd3000, px + 2000, pz - 1500, 512, 16'h2100, 100));
    send_word(make_query(0, 32'd2500));
    send_word(make_query(0, 32'd3000));
    send_word(make_query(0, 32'd4000));
    send_word(make_query(0, 32'd5047));
    send_word(make_query(0, 32'd5048));
    send_word(make_query(0, 32'd4000));
    dead_reckon(0, 32'd6000, px, pz, pb);
    send_word(make_report(0, 32'd6000, px + 100000, pz, 512, 16'h2000, 100));
    dead_reckon(0, 32'd7000, px, pz, pb);
    send_word(make_report(0, 32'd7000, px + 10, pz + 10, 512, 16'h2000, 100));
    send_word(make_query(0, 32'd7500));
    send_word(make_report(63, 32'hFFFF_0000, 64'sd2147483647, -64'sd2147483648,
                          32767, 16'hFFFF, -32768));
    send_word(make_query(63, 32'hFFFF_FFFF));
    send_word(make_report(63, 32'hFFFF_FFFF, -64'sd2147483648, 64'sd2147483647,
                          -32768, 0, 32767));
    send_word(make_query(63, 32'h0000_0010));
    send_word(make_report(1, 32'd1, 0, 0, 32767, 16'h8000, 32767));
    send_word(make_query(1, 32'hFFFF_FFFF));
    drain();
    // Out-of-range entries
    program_regs(7'd5, 31'd12800, 16'd26, 16'd2048);
    send_word(make_query(5, 32'd9000));
    send_word(make_report(63, 32'd9000, 1, 1, 1, 1, 1));
    send_word(make_query(4, 32'd9000));
    drain();
  endtask

  // Register extremes: no vessels, all vessels, widest thresholds, zero blend
  task automatic test_reg_extremes;
    program_regs(7'd0, 31'd12800, 16'd26, 16'd2048);
    for (int i = 0; i < 6; i++) send_word(noise_word());
    drain();
    program_regs(7'd127, 31'h7FFF_FFFF, 16'd0, 16'd0);
    for (int i = 0; i < 40; i++) send_word(plausible_word(4));
    drain();
    program_regs(7'd64, 31'd0, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 40; i++) send_word(plausible_word(4));
    drain();
  endtask

  // Mostly plausible sequences, a share of raw noise, idling toggled in stretches
  task automatic test_random_traffic;
    logic [6:0]  sc  [4] = '{7'd64, 7'd8, 7'd127, 7'd40};
    logic [30:0] st  [4] = '{31'd12800, 31'h7FFF_FFFF, 31'd40000, 31'd2000};
    logic [15:0] mc  [4] = '{16'd26, 16'd0, 16'd100, 16'd5};
    logic [15:0] bt  [4] = '{16'd2048, 16'hFFFF, 16'd1, 16'd600};
    int          nv;
    for (int ph = 0; ph < 4; ph++) begin
      program_regs(sc[ph], st[ph], mc[ph], bt[ph]);
      nv = (ph == 2) ? 64 : $urandom_range(3, 12);
      for (int i = 0; i < 310; i++) begin
        if (i % 60 == 0) begin
          tx_calm = ($urandom_range(0, 3) == 0);
          rx_calm = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 9) < 8) send_word(plausible_word(nv));
        else send_word(noise_word());
      end
      tx_calm = 1'b0;
      rx_calm = 1'b0;
      drain();
    end
  endtask

  // Hold the result side off while words keep coming, so the input stalls
  task automatic test_backpressure;
    program_regs(7'd64, 31'd12800, 16'd26, 16'd2048);
    tx_calm  = 1'b1;
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++) send_word(plausible_word(6));
    tx_calm = 1'b0;
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready with one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    res_ch.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_off) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      n = rx_calm ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(negedge clk); while (!res_ch.valid);
      @(posedge clk);
    end
  end

  // Compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      checked++;
      if (pending_fixes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", res_ch.data);
      end else begin
        want = pending_fixes.pop_front();
        if (res_ch.data.in_range !== want.in_range || res_ch.data.out_x !== want.out_x ||
            res_ch.data.out_z !== want.out_z || res_ch.data.out_speed !== want.out_speed ||
            res_ch.data.out_bearing !== want.out_bearing ||
            res_ch.data.out_turn !== want.out_turn) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected %p, got %p", checked, want, res_ch.data);
        end
      end
    end
  end

  // Watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_SHIP_COUNT;
    cfg_data      = '0;
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    mismatches    = 0;
    checked       = 0;
    words_sent    = 0;
    reports_sent  = 0;
    queries_sent  = 0;
    idle_cycles   = 0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    hold_off      = 1'b0;
    for (int i = 0; i < N_VESSEL; i++) begin
      tracks[i]   = '{default: '0};
      clock_of[i] = 32'd0;
    end
    m_ship_count = SHIP_COUNT_RST;
    m_snap       = SNAP_RST;
    m_min_corr   = MIN_CORR_RST;
    m_blend_time = BLEND_TIME_RST;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_reg_extremes();
    test_backpressure();
    test_random_traffic();
    drain();

    if (pending_fixes.size() != 0) mismatches++;
    $display("Covered %0d words (%0d reports, %0d queries), %0d results checked,",
             words_sent, reports_sent, queries_sent, checked);
    $display("over ten register settings with random idling and one long output stall.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
